[design/edh_pkg.sv]
// Shared types and constants for the edge deduplication hash table.
package edh_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int VERT_W      = 9;
    localparam int POS_W       = 10;
    localparam int REQ_W       = 2;
    localparam int HASH_MULT   = 5;
    localparam int KEY_W       = 12;
    localparam int MOD_BITS_PER_CYC = 2;

    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [VERT_W-1:0] first_vertex;
        logic [VERT_W-1:0] second_vertex;
        logic              edge_class;
        logic [POS_W-1:0]  list_position;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_index;
        logic               is_new;
        logic               stored_class;
        logic               table_full;
        logic [COUNT_W-1:0] entry_count;
        logic [VERT_W-1:0]  low_vertex;
        logic [VERT_W-1:0]  high_vertex;
    } t_out_item;

    typedef struct packed {
        logic              occupied;
        logic [VERT_W-1:0] low_vertex;
        logic [VERT_W-1:0] high_vertex;
        logic              edge_class;
    } t_slot_entry;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RD_LIST,
        S_RD_SLOT,
        S_EMIT
    } t_state;

endpackage

[design/edh_mod.sv]
// Multi-cycle remainder unit: key mod table size, two bits per cycle.
module edh_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [edh_pkg::KEY_W-1:0]   i_key,
    input  logic [edh_pkg::COUNT_W-1:0] i_size,
    output logic                        o_done,
    output logic [edh_pkg::SLOT_W-1:0]  o_rem
);
    import edh_pkg::*;

    localparam int STEPS = KEY_W / MOD_BITS_PER_CYC;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [KEY_W-1:0]   r_dvd;
    logic [COUNT_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    logic [KEY_W-1:0]   n_dvd;
    logic [COUNT_W-1:0] n_rem;

    // restoring remainder steps, MSB of the key first
    always_comb begin
        logic [COUNT_W:0] trial;
        n_dvd = r_dvd;
        n_rem = r_rem;
        for (int i = 0; i < MOD_BITS_PER_CYC; i++) begin
            trial = {n_rem, n_dvd[KEY_W-1]};
            n_dvd = {n_dvd[KEY_W-2:0], 1'b0};
            if (trial >= {1'b0, i_size}) begin
                trial = trial - {1'b0, i_size};
            end
            n_rem = trial[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_key;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[SLOT_W-1:0];

endmodule

[design/edge_dedup_hash_table.sv]
// Top level of the edge deduplication hash table.
//
// Deduplicating edge table with open addressing and linear probing. An add
// item orders its vertex pair (smaller first), hashes it as (low*5 + high)
// mod the effective table size, then probes upward with wrap until it finds
// the same pair (class becomes the lower of stored and requested) or an empty
// slot (pair stored, slot appended to the insertion-order list). If every
// slot below the size is taken by other pairs, the result has table_full set
// and nothing changes. A clear item empties the table; a read item returns
// the entry at an insertion position. Each item gives exactly one result.
// table_size is taken saturated into 1..1024 (0 acts as 1) and may only be
// written while the block is idle.
// Timing: one item at a time. An add first gets its hash from the
// two-bit-per-cycle remainder unit, then probes one slot after another
// (1 to table size slots), the slot memory read for each probe being issued
// ahead of it and registered. A read goes through the list memory, then the
// slot memory. A clear, and also the time after reset, runs a pass over all
// 1024 slots that clears the occupied flags, one slot per cycle, before the
// next item is taken (configuration writes are accepted during the pass).
// Results sit in an output register, so a new item is taken while a result
// waits.
module edge_dedup_hash_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [edh_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  edh_pkg::t_in_item           i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output edh_pkg::t_out_item          o_out
);
    import edh_pkg::*;

    // control
    t_state             r_state;
    t_state             n_state;
    logic               r_sweep_emit;   // clear pending: emit after sweep
    logic [SLOT_W-1:0]  r_sweep;
    logic [COUNT_W-1:0] r_table_size;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;

    // item context
    logic [VERT_W-1:0]  r_lo;
    logic [VERT_W-1:0]  r_hi;
    logic               r_cls;
    logic [POS_W-1:0]   r_pos;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_home;
    logic [COUNT_W-1:0] r_probes;
    t_out_item          r_res;
    t_out_item          r_out;

    // memories
    t_slot_entry        slot_mem [TABLE_DEPTH];
    logic [SLOT_W-1:0]  order_mem [TABLE_DEPTH];
    t_slot_entry        r_slot_q;
    logic [SLOT_W-1:0]  r_order_q;

    logic               slot_we;
    logic [SLOT_W-1:0]  slot_waddr;
    t_slot_entry        slot_wdata;
    logic [SLOT_W-1:0]  slot_raddr;
    logic               order_we;
    logic [SLOT_W-1:0]  order_raddr;

    logic               in_accept;
    logic               load_out;
    logic               div_start;
    logic               div_done;
    logic [SLOT_W-1:0]  div_rem;
    logic [COUNT_W-1:0] eff_size;
    logic [VERT_W-1:0]  in_lo;
    logic [VERT_W-1:0]  in_hi;
    logic [KEY_W-1:0]   in_key;
    logic [SLOT_W-1:0]  n_slot;
    logic               probe_empty;
    logic               probe_match;
    logic               probe_last;
    logic               count_room;
    logic               sweep_last;

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    assign eff_size = (r_table_size == '0) ? COUNT_W'(1) :
                      (r_table_size > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) :
                      r_table_size;

    assign in_lo  = (i_in.first_vertex < i_in.second_vertex) ? i_in.first_vertex
                                                             : i_in.second_vertex;
    assign in_hi  = (i_in.first_vertex < i_in.second_vertex) ? i_in.second_vertex
                                                             : i_in.first_vertex;
    assign in_key = KEY_W'(HASH_MULT) * KEY_W'(in_lo) + KEY_W'(in_hi);

    // next probe slot, wrapping at the effective size
    assign n_slot = (({1'b0, r_slot} + COUNT_W'(1)) == eff_size) ? '0
                                                                  : r_slot + SLOT_W'(1);

    assign probe_empty = !r_slot_q.occupied;
    assign probe_match = r_slot_q.occupied && (r_slot_q.low_vertex == r_lo)
                         && (r_slot_q.high_vertex == r_hi);
    assign probe_last  = (r_probes == (eff_size - COUNT_W'(1)));
    assign count_room  = (r_count < COUNT_W'(TABLE_DEPTH));
    assign sweep_last  = (r_sweep == SLOT_W'(TABLE_DEPTH - 1));

    assign in_accept = i_in_valid && !o_in_stall;
    assign load_out  = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);

    edh_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_key   (in_key),
        .i_size  (eff_size),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_SWEEP: begin
                if (sweep_last) begin
                    n_state = r_sweep_emit ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (i_in.req_type)
                        REQ_ADD:   n_state = S_HASH;
                        REQ_CLEAR: n_state = S_SWEEP;
                        REQ_READ:  n_state = S_RD_LIST;
                        default:   n_state = S_EMIT;
                    endcase
                end
            end
            S_HASH: begin
                if (div_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (probe_empty || probe_match || probe_last) begin
                    n_state = S_EMIT;
                end
            end
            S_RD_LIST: n_state = S_RD_SLOT;
            S_RD_SLOT: n_state = S_EMIT;
            S_EMIT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs: handshake and memory controls
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        div_start   = 1'b0;
        slot_we     = 1'b0;
        slot_waddr  = r_slot;
        slot_wdata  = '{occupied: 1'b1, low_vertex: r_lo, high_vertex: r_hi,
                        edge_class: r_cls};
        slot_raddr  = r_slot;
        order_we    = 1'b0;
        order_raddr = (r_state == S_IDLE) ? i_in.list_position : r_pos;
        case (r_state)
            S_SWEEP: begin
                slot_we    = 1'b1;
                slot_waddr = r_sweep;
                slot_wdata = '0;
            end
            S_IDLE: begin
                div_start = in_accept && (i_in.req_type == REQ_ADD);
            end
            S_HASH: begin
                slot_raddr = div_rem;
            end
            S_PROBE: begin
                slot_raddr = n_slot;
                if (probe_empty) begin
                    slot_we  = 1'b1;
                    order_we = count_room;
                end else if (probe_match) begin
                    slot_we = 1'b1;
                    slot_wdata.edge_class = r_cls & r_slot_q.edge_class;
                end
            end
            S_RD_LIST: begin
                slot_raddr = r_order_q;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories: one write and one registered read per cycle each
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        r_slot_q <= slot_mem[slot_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (order_we) begin
            order_mem[r_count[SLOT_W-1:0]] <= r_slot;
        end
        r_order_q <= order_mem[order_raddr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_SWEEP;
            r_sweep      <= '0;
            r_sweep_emit <= 1'b0;
            r_table_size <= COUNT_W'(TABLE_DEPTH);
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            if (r_state == S_SWEEP) begin
                r_sweep <= r_sweep + SLOT_W'(1);
                if (sweep_last) begin
                    r_sweep_emit <= 1'b0;
                end
            end
            if (in_accept && (i_in.req_type == REQ_CLEAR)) begin
                r_sweep      <= '0;
                r_sweep_emit <= 1'b1;
                r_count      <= '0;
            end
            if ((r_state == S_PROBE) && probe_empty && count_room) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Item context and result
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    r_lo  <= in_lo;
                    r_hi  <= in_hi;
                    r_cls <= i_in.edge_class;
                    r_pos <= i_in.list_position;
                    // clear reports a zero count, everything else the current one
                    r_res <= '{slot_index: '0, is_new: 1'b0, stored_class: 1'b0,
                               table_full: 1'b0,
                               entry_count: (i_in.req_type == REQ_CLEAR) ? '0 : r_count,
                               low_vertex: '0, high_vertex: '0};
                end
            end
            S_HASH: begin
                r_slot   <= div_rem;
                r_home   <= div_rem;
                r_probes <= '0;
            end
            S_PROBE: begin
                r_slot   <= n_slot;
                r_probes <= r_probes + COUNT_W'(1);
                r_res.low_vertex  <= r_lo;
                r_res.high_vertex <= r_hi;
                r_res.entry_count <= (probe_empty && count_room) ? r_count + COUNT_W'(1)
                                                                 : r_count;
                if (probe_empty) begin
                    r_res.slot_index   <= r_slot;
                    r_res.is_new       <= 1'b1;
                    r_res.stored_class <= r_cls;
                    r_res.table_full   <= 1'b0;
                end else if (probe_match) begin
                    r_res.slot_index   <= r_slot;
                    r_res.is_new       <= 1'b0;
                    r_res.stored_class <= r_cls & r_slot_q.edge_class;
                    r_res.table_full   <= 1'b0;
                end else begin
                    // full: home slot, no state change
                    r_res.slot_index   <= r_home;
                    r_res.is_new       <= 1'b0;
                    r_res.stored_class <= 1'b0;
                    r_res.table_full   <= 1'b1;
                end
            end
            S_RD_SLOT: begin
                if ({1'b0, r_pos} < r_count) begin
                    r_res.slot_index   <= r_order_q;
                    r_res.stored_class <= r_slot_q.edge_class;
                    r_res.low_vertex   <= r_slot_q.low_vertex;
                    r_res.high_vertex  <= r_slot_q.high_vertex;
                end
            end
            default: ;
        endcase
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[design/edh_checker.sv]
// Port-level checker for the edge deduplication hash table, with its bind.
module edh_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input edh_pkg::t_out_item  o_out
);
    import edh_pkg::*;

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.entry_count <= COUNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_new_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.is_new && o_out.table_full))
        else $error("result both new and full");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.low_vertex <= o_out.high_vertex)
        else $error("vertex pair out of order");

endmodule

bind edge_dedup_hash_table edh_checker u_edh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

[verif/tb.sv]
// Self-checking testbench for the edge deduplication hash table.
module tb;
    import edh_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS   = 108;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [COUNT_W-1:0] i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out;

    edge_dedup_hash_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Shadow copy of the edge table, kept in step with accepted items.
    logic [COUNT_W-1:0] size_reg = COUNT_W'(TABLE_DEPTH);
    bit                 occ       [TABLE_DEPTH];
    logic [VERT_W-1:0]  lo_mem    [TABLE_DEPTH];
    logic [VERT_W-1:0]  hi_mem    [TABLE_DEPTH];
    logic               cls_mem   [TABLE_DEPTH];
    logic [SLOT_W-1:0]  order_mem [TABLE_DEPTH];
    int unsigned        edge_count = 0;

    t_out_item pending_q[$];
    int n_errors = 0, n_results = 0, n_adds = 0, n_new = 0, n_full = 0;
    int n_reads = 0, n_clears = 0, n_other = 0;
    int cycle_cnt = 0;
    bit quiet = 1'b0;

    typedef struct {
        bit        is_cfg;
        int        cfg_value;
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_plan_row;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Result of one item against the shadow table; updates the shadow table.
    function automatic t_out_item predict_edge(input t_in_item it);
        t_out_item         r;
        logic [VERT_W-1:0] lo, hi;
        int unsigned       sz, home, slot, probe;
        bit                done;
        r = '0;
        done = 1'b0;
        case (it.req_type)
            REQ_ADD: begin
                n_adds++;
                lo = (it.first_vertex < it.second_vertex) ? it.first_vertex : it.second_vertex;
                hi = (it.first_vertex < it.second_vertex) ? it.second_vertex : it.first_vertex;
                sz = 32'(size_reg);
                if (sz < 1) sz = 1;
                if (sz > TABLE_DEPTH) sz = TABLE_DEPTH;
                home = (int'(lo) * HASH_MULT + int'(hi)) % sz;
                slot = home;
                r.low_vertex  = lo;
                r.high_vertex = hi;
                for (probe = 0; probe < sz && !done; probe++) begin
                    if (!occ[slot]) begin
                        occ[slot]     = 1'b1;
                        lo_mem[slot]  = lo;
                        hi_mem[slot]  = hi;
                        cls_mem[slot] = it.edge_class;
                        if (edge_count < TABLE_DEPTH) begin
                            order_mem[edge_count] = SLOT_W'(slot);
                            edge_count++;
                        end
                        r.slot_index   = SLOT_W'(slot);
                        r.is_new       = 1'b1;
                        r.stored_class = it.edge_class;
                        n_new++;
                        done = 1'b1;
                    end else if (lo_mem[slot] == lo && hi_mem[slot] == hi) begin
                        // lower class wins
                        if (it.edge_class < cls_mem[slot]) cls_mem[slot] = it.edge_class;
                        r.slot_index   = SLOT_W'(slot);
                        r.stored_class = cls_mem[slot];
                        done = 1'b1;
                    end else begin
                        slot = (slot + 1 >= sz) ? 0 : slot + 1;
                    end
                end
                if (!done) begin
                    // every slot below the size holds another pair
                    r.slot_index = SLOT_W'(home);
                    r.table_full = 1'b1;
                    n_full++;
                end
                r.entry_count = COUNT_W'(edge_count);
            end
            REQ_CLEAR: begin
                n_clears++;
                foreach (occ[k]) occ[k] = 1'b0;
                edge_count = 0;
            end
            REQ_READ: begin
                n_reads++;
                r.entry_count = COUNT_W'(edge_count);
                if (it.list_position < edge_count) begin
                    slot = 32'(order_mem[it.list_position]);
                    r.slot_index   = SLOT_W'(slot);
                    r.stored_class = cls_mem[slot];
                    r.low_vertex   = lo_mem[slot];
                    r.high_vertex  = hi_mem[slot];
                end
            end
            default: begin
                n_other++;
                r.entry_count = COUNT_W'(edge_count);
            end
        endcase
        return r;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_plan_row req_row(input logic [REQ_W-1:0] req, input int fv,
                                          input int sv, input int cls, input int pos);
        t_plan_row r;
        r.is_cfg             = 1'b0;
        r.cfg_value          = 0;
        r.typed              = 1'b0;
        r.want               = '0;
        r.item.req_type      = req;
        r.item.first_vertex  = VERT_W'(fv);
        r.item.second_vertex = VERT_W'(sv);
        r.item.edge_class    = cls[0];
        r.item.list_position = POS_W'(pos);
        return r;
    endfunction

    function automatic t_plan_row known(input t_plan_row row, input int slot, input int nw,
                                        input int cls, input int full, input int cnt,
                                        input int lo, input int hi);
        t_plan_row r;
        r = row;
        r.typed             = 1'b1;
        r.want.slot_index   = SLOT_W'(slot);
        r.want.is_new       = nw[0];
        r.want.stored_class = cls[0];
        r.want.table_full   = full[0];
        r.want.entry_count  = COUNT_W'(cnt);
        r.want.low_vertex   = VERT_W'(lo);
        r.want.high_vertex  = VERT_W'(hi);
        return r;
    endfunction

    function automatic t_plan_row cfg_row(input int value);
        t_plan_row r;
        r.is_cfg    = 1'b1;
        r.cfg_value = value;
        r.item      = '0;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    task automatic mismatch(input string field, input logic [31:0] want_v,
                            input logic [31:0] got_v);
        $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
        n_errors++;
    endtask

    task automatic compare_fields(input t_out_item want, input t_out_item got);
        if (got.slot_index !== want.slot_index)
            mismatch("slot_index", 32'(want.slot_index), 32'(got.slot_index));
        if (got.is_new !== want.is_new)
            mismatch("is_new", 32'(want.is_new), 32'(got.is_new));
        if (got.stored_class !== want.stored_class)
            mismatch("stored_class", 32'(want.stored_class), 32'(got.stored_class));
        if (got.table_full !== want.table_full)
            mismatch("table_full", 32'(want.table_full), 32'(got.table_full));
        if (got.entry_count !== want.entry_count)
            mismatch("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        if (got.low_vertex !== want.low_vertex)
            mismatch("low_vertex", 32'(want.low_vertex), 32'(got.low_vertex));
        if (got.high_vertex !== want.high_vertex)
            mismatch("high_vertex", 32'(want.high_vertex), 32'(got.high_vertex));
    endtask

    // Valid rises at a falling edge and holds with its payload until accepted.
    task automatic send_item(input t_in_item it, input bit typed_exp, input t_out_item given);
        int        gap;
        t_out_item predicted;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_edge(it);
        pending_q.push_back(typed_exp ? given : predicted);
    endtask

    // Size writes only once the block has drained and settled.
    task automatic apply_size(input int value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= COUNT_W'(value);
        size_reg     = COUNT_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Output side: random back-pressure, held over runs of cycles.
    initial begin : out_stall_gen
        int hold;
        hold = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else begin
                hold = pick_gap();
                i_out_stall <= (hold > 0);
                if (hold > 0) hold--;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out);
                n_errors++;
            end else begin
                want = pending_q.pop_front();
                compare_fields(want, o_out);
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                 pending_q.size());
        $display("tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_plan_row               plan[$];
        t_in_item                it;
        logic [31:0]             stim;
        logic [2*VERT_W-1:0]     pool[$];
        logic [2*VERT_W-1:0]     pair;
        int                      roll, phase, k;
        int                      phase_sizes[12] = '{1024, 1, 3, 2047, 16, 0, 2, 64, 1024, 5,
                                                      700, 8};
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, vertex extremes, dedup and class merge,
        // reads in and beyond range, unknown request, collision, clear,
        // size 0 acting as 1, full table, size change without clear.
        plan.push_back(known(req_row(REQ_READ, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(known(req_row(REQ_ADD, 0, 0, 0, 0), 0, 1, 0, 0, 1, 0, 0));
        plan.push_back(known(req_row(REQ_ADD, 511, 511, 1, 0), 1018, 1, 1, 0, 2, 511, 511));
        plan.push_back(known(req_row(REQ_ADD, 511, 0, 1, 0), 511, 1, 1, 0, 3, 0, 511));
        plan.push_back(known(req_row(REQ_ADD, 0, 511, 0, 0), 511, 0, 0, 0, 3, 0, 511));
        plan.push_back(known(req_row(REQ_ADD, 0, 511, 1, 0), 511, 0, 0, 0, 3, 0, 511));
        plan.push_back(known(req_row(REQ_READ, 0, 0, 0, 2), 511, 0, 0, 0, 3, 0, 511));
        plan.push_back(known(req_row(REQ_READ, 511, 511, 1, 1023), 0, 0, 0, 0, 3, 0, 0));
        plan.push_back(known(req_row(REQ_READ, 0, 0, 0, 3), 0, 0, 0, 0, 3, 0, 0));
        plan.push_back(known(req_row(REQ_UNKNOWN, 511, 511, 1, 1023), 0, 0, 0, 0, 3, 0, 0));
        plan.push_back(known(req_row(REQ_ADD, 509, 103, 1, 0), 1, 1, 1, 0, 4, 103, 509));
        plan.push_back(known(req_row(REQ_CLEAR, 511, 511, 1, 1023), 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(cfg_row(0));
        plan.push_back(known(req_row(REQ_ADD, 3, 4, 1, 0), 0, 1, 1, 0, 1, 3, 4));
        plan.push_back(known(req_row(REQ_ADD, 2, 1, 0, 0), 0, 0, 0, 1, 1, 1, 2));
        plan.push_back(known(req_row(REQ_ADD, 4, 3, 0, 0), 0, 0, 0, 0, 1, 3, 4));
        plan.push_back(cfg_row(2047));
        plan.push_back(req_row(REQ_ADD, 3, 4, 1, 0));
        plan.push_back(req_row(REQ_READ, 0, 0, 0, 1));
        plan.push_back(cfg_row(3));
        plan.push_back(req_row(REQ_ADD, 1, 1, 1, 0));
        plan.push_back(req_row(REQ_ADD, 0, 2, 0, 0));
        plan.push_back(req_row(REQ_ADD, 5, 0, 1, 0));
        plan.push_back(req_row(REQ_READ, 0, 0, 0, 0));
        plan.push_back(req_row(REQ_CLEAR, 0, 0, 0, 0));

        foreach (plan[r]) begin
            if (plan[r].is_cfg) apply_size(plan[r].cfg_value);
            else send_item(plan[r].item, plan[r].typed, plan[r].want);
        end

        // Random phases, one table size each; some phases run without gaps.
        for (phase = 0; phase < 12; phase++) begin
            apply_size(phase_sizes[phase]);
            quiet = (phase % 4 == 2);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                stim = $urandom;
                it   = stim[$bits(t_in_item)-1:0];
                roll = $urandom_range(0, 99);
                if (roll < 72) begin
                    it.req_type = REQ_ADD;
                    if (pool.size() != 0 && $urandom_range(0, 99) < 40) begin
                        // repeat a known pair, either order
                        pair = pool[$urandom_range(0, pool.size() - 1)];
                        if ($urandom_range(0, 1) == 1)
                            {it.first_vertex, it.second_vertex} = pair;
                        else
                            {it.second_vertex, it.first_vertex} = pair;
                    end else begin
                        // small vertices crowd the low hash slots
                        if ($urandom_range(0, 99) < 20) begin
                            it.first_vertex  = VERT_W'($urandom_range(0, 15));
                            it.second_vertex = VERT_W'($urandom_range(0, 15));
                        end
                        pool.push_back({it.first_vertex, it.second_vertex});
                        if (pool.size() > 48) void'(pool.pop_front());
                    end
                end else if (roll < 90) begin
                    it.req_type = REQ_READ;
                    if (edge_count != 0 && $urandom_range(0, 3) != 0)
                        it.list_position = POS_W'($urandom_range(0, edge_count));
                end else if (roll < 94) begin
                    it.req_type = REQ_CLEAR;
                end else begin
                    it.req_type = REQ_UNKNOWN;
                end
                send_item(it, 1'b0, '0);
            end
        end

        quiet = 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Items: %0d adds (%0d new, %0d table full), %0d reads, %0d clears, %0d unknown",
                 n_adds, n_new, n_full, n_reads, n_clears, n_other);
        $display("Results checked: %0d over table sizes 0..2047, mismatches: %0d",
                 n_results, n_errors);
        if (n_errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
